// ----- hdl/fas_pkg.sv -----
// Package: constants and types shared by the single-precision add/sub unit.
package fas_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ExpW   = 8;
    localparam int unsigned FracW  = 23;
    localparam int unsigned MagW   = 32;
    localparam int unsigned PosW   = 5;
    localparam int unsigned TdataInW = 64;

    localparam logic [ExpW-1:0] ExpMax = 8'hFF;

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_SUB = 1'b1
    } mode_t;

endpackage

// ----- hdl/float32_add_sub_unit.sv -----
// Top level: pipelined single-precision adder/subtractor with truncation.
module float32_add_sub_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_bits [31:0], b_bits [63:32]
    input  logic [fas_pkg::TdataInW-1:0]   s_tdata,
    // mode [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sum_bits [31:0]
    output logic [fas_pkg::WordW-1:0]      m_tdata
);
    // One request enters per clock while the pipeline advances. The path is cut
    // into four register stages: operand swap and exponent difference, alignment
    // shift and signed add, leading-one search, and normalize/pack. All stages
    // advance together whenever the output register is free or being read, so
    // back-to-back requests flow at one per cycle.
    import fas_pkg::*;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---- stage 1: unpack, choose larger exponent, difference
    logic        v1_reg;
    logic        sx_reg, sy_reg;
    logic [ExpW-1:0] base1_reg, dist1_reg;
    logic [23:0] mx_reg, my_reg;

    logic [31:0] a_w, b_w;
    logic        a_big;
    always_comb begin
        a_w = s_tdata[31:0];
        b_w = s_tdata[63:32];
        if (mode_t'(s_tuser) == MODE_SUB) begin
            b_w[31] = ~b_w[31];
        end
        a_big = a_w[30:23] > b_w[30:23];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (a_big) begin
                sx_reg    <= a_w[31];
                mx_reg    <= {1'b1, a_w[22:0]};
                sy_reg    <= b_w[31];
                my_reg    <= {1'b1, b_w[22:0]};
                base1_reg <= a_w[30:23];
                dist1_reg <= a_w[30:23] - b_w[30:23];
            end else begin
                sx_reg    <= b_w[31];
                mx_reg    <= {1'b1, b_w[22:0]};
                sy_reg    <= a_w[31];
                my_reg    <= {1'b1, a_w[22:0]};
                base1_reg <= b_w[30:23];
                dist1_reg <= b_w[30:23] - a_w[30:23];
            end
        end
    end

    // ---- stage 2: align smaller operand, add or subtract magnitudes
    logic        v2_reg, sign2_reg;
    logic [ExpW-1:0] base2_reg;
    logic [MagW-1:0] mag2_reg;

    logic [MagW-1:0] ex, ey, sum_n;
    logic            sign_n;
    always_comb begin
        ex = {1'b0, mx_reg, 7'd0};
        ey = (dist1_reg >= 8'd32) ? '0 : ({1'b0, my_reg, 7'd0} >> dist1_reg[4:0]);
        if (sx_reg == sy_reg) begin
            sum_n  = ex + ey;
            sign_n = sx_reg;
        end else if (ex >= ey) begin
            sum_n  = ex - ey;
            sign_n = sx_reg;
        end else begin
            sum_n  = ey - ex;
            sign_n = sy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            mag2_reg  <= sum_n;
            sign2_reg <= sign_n;
            base2_reg <= base1_reg;
        end
    end

    // ---- stage 3: leading-one detect
    logic        v3_reg, sign3_reg, zero3_reg;
    logic [ExpW-1:0] base3_reg;
    logic [MagW-1:0] mag3_reg;
    logic [PosW-1:0] pos3_reg;

    logic [PosW-1:0] pos_n;
    always_comb begin
        pos_n = '0;
        for (int i = 0; i < MagW; i++) begin
            if (mag2_reg[i]) begin
                pos_n = PosW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            mag3_reg  <= mag2_reg;
            pos3_reg  <= pos_n;
            zero3_reg <= (mag2_reg == '0);
            sign3_reg <= sign2_reg;
            base3_reg <= base2_reg;
        end
    end

    // ---- stage 4: exponent adjust, normalize shift, pack
    logic        v4_reg;
    logic [WordW-1:0] res4_reg;

    logic signed [10:0] e_n;
    logic [MagW-1:0]    norm;
    logic [WordW-1:0]   res_n;
    always_comb begin
        e_n  = $signed({3'b000, base3_reg}) + $signed({6'd0, pos3_reg}) - 11'sd30;
        norm = mag3_reg << (5'd31 - pos3_reg);
        if (zero3_reg) begin
            res_n = '0;
        end else if (e_n < 0) begin
            res_n = {sign3_reg, 31'd0};
        end else if (e_n >= 11'sd255) begin
            res_n = {sign3_reg, ExpMax, 23'd0};
        end else begin
            res_n = {sign3_reg, e_n[7:0], norm[30:8]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            res4_reg <= res_n;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = res4_reg;

endmodule
